// ===== hdl/ute_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 key event transcoder.
package ute_pkg;

   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int CP_W    = 21;
   localparam int OWED_W  = 2;
   localparam int STEP_W  = 2;

   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

   localparam logic [CP_W-1:0]   MAX_CP      = 21'h10FFFF;
   localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h010000;
   localparam logic [UNIT_W-1:0] HIGH_SURR   = 16'hD800;
   localparam logic [UNIT_W-1:0] LOW_SURR    = 16'hDC00;

   localparam logic [STEP_W-1:0] STEP_HI_DOWN = 2'd0;
   localparam logic [STEP_W-1:0] STEP_HI_UP   = 2'd1;
   localparam logic [STEP_W-1:0] STEP_LO_UP   = 2'd3;

   // One decoded code point waiting to be sent as key events.
   typedef struct packed {
      logic [UNIT_W-1:0] unit_hi;
      logic [UNIT_W-1:0] unit_lo;
      logic              pair;
      logic              text_last;
   } job_type;

endpackage

// ===== hdl/ute_decode.sv =====
// Input register and lenient UTF-8 decoder that turns bytes into code point jobs.
module ute_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ute_pkg::BYTE_W-1:0]  req_byte_in,
   input  logic                        req_text_last,
   output logic                        job_valid,
   output ute_pkg::job_type            job,
   input  logic                        job_ready
);
   import ute_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic [CP_W-1:0]   partial_ff, partial_in;
   logic [OWED_W-1:0] owed_ff, owed_in;

   logic [CP_W-1:0]   cont_bits;
   logic [CP_W-1:0]   cp_next;
   logic [CP_W-1:0]   cp_off;
   logic [OWED_W-1:0] owed_next;
   logic              done;
   logic              emit_any;
   logic              in_take;

   always_comb begin
      case (owed_ff)
         2'd1:    cont_bits = {15'd0, in_byte_ff[5:0]};
         2'd2:    cont_bits = {9'd0, in_byte_ff[5:0], 6'd0};
         2'd3:    cont_bits = {3'd0, in_byte_ff[5:0], 12'd0};
         default: cont_bits = '0;
      endcase
   end

   always_comb begin
      cp_next   = partial_ff;
      owed_next = '0;
      done      = 1'b0;
      if (owed_ff != '0) begin
         cp_next   = partial_ff | cont_bits;
         owed_next = owed_ff - 2'd1;
         done      = (owed_next == '0);
      end else if (!in_byte_ff[7]) begin
         cp_next = {13'd0, in_byte_ff};
         done    = 1'b1;
      end else if ((in_byte_ff & LEAD2_MASK) == LEAD2_CODE) begin
         cp_next   = {10'd0, in_byte_ff[4:0], 6'd0};
         owed_next = 2'd1;
      end else if ((in_byte_ff & LEAD3_MASK) == LEAD3_CODE) begin
         cp_next   = {5'd0, in_byte_ff[3:0], 12'd0};
         owed_next = 2'd2;
      end else if ((in_byte_ff & LEAD4_MASK) == LEAD4_CODE) begin
         cp_next   = {in_byte_ff[2:0], 18'd0};
         owed_next = 2'd3;
      end
      if (!done && in_last_ff && owed_next != '0) begin
         done = 1'b1;
      end
   end

   assign emit_any = done && (cp_next <= MAX_CP);
   assign cp_off   = cp_next - SUPP_BASE;

   always_comb begin
      job.pair      = (cp_next[20:16] != 5'd0);
      job.text_last = in_last_ff;
      job.unit_lo   = LOW_SURR | {6'd0, cp_off[9:0]};
      if (cp_next[20:16] != 5'd0) begin
         job.unit_hi = HIGH_SURR | {6'd0, cp_off[19:10]};
      end else begin
         job.unit_hi = cp_next[15:0];
      end
   end

   assign job_valid   = in_valid_ff && emit_any;
   assign in_take     = in_valid_ff && (!emit_any || job_ready);
   assign req_ready   = !in_valid_ff || in_take;
   assign in_valid_in = req_valid || (in_valid_ff && !in_take);

   always_comb begin
      partial_in = partial_ff;
      owed_in    = owed_ff;
      if (in_take) begin
         owed_in    = in_last_ff ? '0 : owed_next;
         partial_in = (done || in_last_ff) ? '0 : cp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         partial_ff  <= '0;
         owed_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         partial_ff  <= partial_in;
         owed_ff     <= owed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
         in_last_ff <= req_text_last;
      end
   end

`ifndef SYNTH
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      in_take && in_last_ff |=> owed_ff == '0 && partial_ff == '0)
      else $error("Sequence still open after the final byte of the text.");

   a_owed_low_zero: assert property (@(posedge clock) disable iff (reset)
      (owed_ff != 2'd1 || partial_ff[5:0] == '0) &&
      (owed_ff != 2'd2 || partial_ff[11:0] == '0) &&
      (owed_ff != 2'd3 || partial_ff[17:0] == '0))
      else $error("Partial code point has bits set below the owed bytes.");

   a_closed_zero: assert property (@(posedge clock) disable iff (reset)
      owed_ff == '0 |-> partial_ff == '0)
      else $error("Partial code point not cleared with no sequence open.");
`endif

endmodule

// ===== hdl/ute_emit.sv =====
// Key event sequencer and output register that sends one event per cycle while rsp_ready is high.
module ute_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  ute_pkg::job_type            job,
   output logic                        job_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ute_pkg::UNIT_W-1:0]  rsp_code_unit,
   output logic                        rsp_key_up,
   output logic                        rsp_run_last,
   output logic                        rsp_text_end
);
   import ute_pkg::*;

   job_type           job_ff;
   logic              job_valid_ff, job_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [UNIT_W-1:0] unit_ff;
   logic              key_up_ff, run_last_ff, text_end_ff;

   logic              out_load;
   logic              last_step;
   logic              job_load;

   assign out_load  = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign last_step = job_ff.pair ? (step_ff == STEP_LO_UP) : (step_ff == STEP_HI_UP);
   assign job_ready = !job_valid_ff || (out_load && last_step);
   assign job_load  = job_valid && job_ready;

   always_comb begin
      job_valid_in = job_valid_ff;
      step_in      = step_ff;
      if (out_load) begin
         step_in = step_ff + 2'd1;
         if (last_step) begin
            job_valid_in = 1'b0;
         end
      end
      if (job_load) begin
         job_valid_in = 1'b1;
         step_in      = STEP_HI_DOWN;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         step_ff      <= STEP_HI_DOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= job;
      end
      if (out_load) begin
         unit_ff     <= step_ff[1] ? job_ff.unit_lo : job_ff.unit_hi;
         key_up_ff   <= step_ff[0];
         run_last_ff <= last_step;
         text_end_ff <= last_step && job_ff.text_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_unit = unit_ff;
   assign rsp_key_up    = key_up_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_text_end  = text_end_ff;

`ifndef SYNTH
   a_single_two_steps: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_ff.pair |-> !step_ff[1])
      else $error("Single unit job stepped past its key-up event.");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && text_end_ff |-> run_last_ff)
      else $error("Text end marked on an event that does not close its byte.");

   a_new_job_first_step: assert property (@(posedge clock) disable iff (reset)
      job_load |=> job_valid_ff && step_ff == STEP_HI_DOWN)
      else $error("New job did not start at its first key-down event.");
`endif

endmodule

// ===== hdl/utf8_to_utf16_key_events.sv =====
// A byte passes the input, job and output registers before its first key event appears.
// Throughput: one key event per cycle while a job waits and rsp_ready is high, set by the
// event sequencer and its output register. A byte that ends a basic plane code point gives
// key-down and key-up, a surrogate pair both for each unit, and other bytes no event.
// Reset is synchronous and closes any open sequence and empties all stages.
module utf8_to_utf16_key_events (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ute_pkg::BYTE_W-1:0]  req_byte_in,
   input  logic                        req_text_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ute_pkg::UNIT_W-1:0]  rsp_code_unit,
   output logic                        rsp_key_up,
   output logic                        rsp_run_last,
   output logic                        rsp_text_end
);
   import ute_pkg::*;

   logic    job_valid;
   logic    job_ready;
   job_type job;

   ute_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .req_text_last (req_text_last),
      .job_valid     (job_valid),
      .job           (job),
      .job_ready     (job_ready)
   );

   ute_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_ready     (job_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_unit (rsp_code_unit),
      .rsp_key_up    (rsp_key_up),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_end  (rsp_text_end)
   );

endmodule
